// ----- sv/cpualu_pkg.sv -----
// ----------------------------------------------------------------------------
// cpualu_pkg
// Shared types and operation codes for the 8-bit ALU with Z N H C flags.
// ----------------------------------------------------------------------------
package cpualu_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned DATA_W = 8;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [DATA_W-1:0] t_byte;

    // Flag word, bit3 down to bit0
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    // Result of one ALU pass
    typedef struct packed {
        t_byte  result;
        t_flags flags;
        logic   wb;
    } t_alu_res;

    // Operation codes
    localparam t_op OP_ADD  = 5'd0;
    localparam t_op OP_ADC  = 5'd1;
    localparam t_op OP_SUB  = 5'd2;
    localparam t_op OP_SBC  = 5'd3;
    localparam t_op OP_CP   = 5'd4;
    localparam t_op OP_AND  = 5'd5;
    localparam t_op OP_XOR  = 5'd6;
    localparam t_op OP_OR   = 5'd7;
    localparam t_op OP_INC  = 5'd8;
    localparam t_op OP_DEC  = 5'd9;
    localparam t_op OP_DAA  = 5'd10;
    localparam t_op OP_CPL  = 5'd11;
    localparam t_op OP_CCF  = 5'd12;
    localparam t_op OP_SCF  = 5'd13;
    localparam t_op OP_RLCA = 5'd14;
    localparam t_op OP_RLA  = 5'd15;
    localparam t_op OP_RRCA = 5'd16;
    localparam t_op OP_RRA  = 5'd17;

    // Decimal adjust constants
    localparam t_byte DAA_LO     = 8'h06;
    localparam t_byte DAA_HI     = 8'h60;
    localparam t_byte DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

endpackage

// ----- sv/cpualu_if.sv -----
// ----------------------------------------------------------------------------
// cpualu_if
// Valid/ready channels for the ALU: operation word in, result word out.
// ----------------------------------------------------------------------------
interface cpualu_req_if;
    logic       valid;
    logic       ready;
    logic [4:0] op;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [3:0] flags_in;

    modport source (output valid, output op, output acc, output operand,
                    output flags_in, input ready);
    modport sink   (input valid, input op, input acc, input operand,
                    input flags_in, output ready);
endinterface

interface cpualu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_back;

    modport source (output valid, output result, output flags_out,
                    output write_back, input ready);
    modport sink   (input valid, input result, input flags_out,
                    input write_back, output ready);
endinterface

// ----- sv/cpu_8bit_alu_with_flags_unit.sv -----
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_unit
// 8-bit ALU with Z N H C flags behind an input register and a result register.
// ----------------------------------------------------------------------------
// One operation word is accepted every cycle while results are being taken.
// A result is offered once its word has passed the input register and then,
// through the single-pass ALU datapath, reached the result register.
// The input register advances when it is empty or the result
// register moves on; the result register advances when it is empty or being
// taken. While a finished result waits, the input register still takes one
// more word and then holds the request side off. Words leave strictly in
// arrival order. Unassigned operation codes pass the accumulator and flags
// through with the write-back mark clear.
module cpu_8bit_alu_with_flags_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpualu_req_if.sink   i_req,
    cpualu_rsp_if.source o_rsp
);
    import cpualu_pkg::*;

    logic     r_in_valid;
    t_op      r_op;
    t_byte    r_acc;
    t_byte    r_operand;
    t_flags   r_flags;
    logic     r_out_valid;
    t_alu_res r_out;

    logic     w_out_free;
    logic     w_in_take;
    t_alu_res w_alu;

    // Pipeline advance control
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || w_out_free;
    assign w_in_take   = i_req.valid && i_req.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op      <= i_req.op;
            r_acc     <= i_req.acc;
            r_operand <= i_req.operand;
            r_flags   <= i_req.flags_in;
        end
    end

    cpualu_core u_core (
        .i_op      (r_op),
        .i_acc     (r_acc),
        .i_operand (r_operand),
        .i_flags   (r_flags),
        .o_res     (w_alu)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_in_valid) begin
            r_out <= w_alu;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.result     = r_out.result;
    assign o_rsp.flags_out  = r_out.flags;
    assign o_rsp.write_back = r_out.wb;

`ifndef NO_ASSERTIONS
    // An accepted word always lands in the input register
    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_valid)
        else $error("accepted word not held in input register");

    // A result only appears from a word that was in the input register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result valid without a word in flight");

    // An empty input register never stalls the request side
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_req.ready)
        else $error("request stalled with empty input register");

    // A compare moved to the result register carries no write-back
    a_cp_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_free && (r_op == OP_CP)) |=> !r_out.wb)
        else $error("compare result marked for write-back");
`endif

endmodule

// ----- sv/cpualu_core.sv -----
// ----------------------------------------------------------------------------
// cpualu_core
// Combinational datapath: arithmetic, logic, decimal adjust, flag ops and
// accumulator rotates, with flag generation.
// ----------------------------------------------------------------------------
module cpualu_core (
    input  cpualu_pkg::t_op      i_op,
    input  cpualu_pkg::t_byte    i_acc,
    input  cpualu_pkg::t_byte    i_operand,
    input  cpualu_pkg::t_flags   i_flags,
    output cpualu_pkg::t_alu_res o_res
);
    import cpualu_pkg::*;

    logic       w_cin_add;
    logic       w_cin_sub;
    logic [8:0] w_sum;
    logic [4:0] w_sum_lo;
    logic [8:0] w_diff;
    logic [4:0] w_diff_lo;
    t_byte      w_inc;
    t_byte      w_dec;
    t_byte      w_daa_hi;
    t_byte      w_daa;
    logic       w_daa_c;
    t_alu_res   w_res;

    // Carry in only for the with-carry forms
    assign w_cin_add = (i_op == OP_ADC) & i_flags.c;
    assign w_cin_sub = (i_op == OP_SBC) & i_flags.c;

    // Adder and subtractor with nibble carries
    assign w_sum     = {1'b0, i_acc} + {1'b0, i_operand} + {8'd0, w_cin_add};
    assign w_sum_lo  = {1'b0, i_acc[3:0]} + {1'b0, i_operand[3:0]} + {4'd0, w_cin_add};
    assign w_diff    = {1'b0, i_acc} - {1'b0, i_operand} - {8'd0, w_cin_sub};
    assign w_diff_lo = {1'b0, i_acc[3:0]} - {1'b0, i_operand[3:0]} - {4'd0, w_cin_sub};

    assign w_inc = i_operand + 8'd1;
    assign w_dec = i_operand - 8'd1;

    // Decimal adjust: add mode does the high digit first, subtract mode the low
    always_comb begin
        w_daa_c  = i_flags.c;
        w_daa_hi = i_acc;
        if (i_flags.n) begin
            if (i_flags.h) w_daa_hi = w_daa_hi - DAA_LO;
            w_daa = i_flags.c ? (w_daa_hi - DAA_HI) : w_daa_hi;
        end else begin
            if (i_flags.c || (i_acc > DAA_HI_MAX)) begin
                w_daa_hi = i_acc + DAA_HI;
                w_daa_c  = 1'b1;
            end
            // high adjust leaves the low nibble alone
            w_daa = (i_flags.h || (i_acc[3:0] > DAA_LO_MAX)) ? (w_daa_hi + DAA_LO)
                                                             : w_daa_hi;
        end
    end

    // Operation select
    always_comb begin
        w_res.result = i_acc;
        w_res.flags  = i_flags;
        w_res.wb     = 1'b1;
        unique case (i_op)
            OP_ADD, OP_ADC: begin
                w_res.result = w_sum[7:0];
                w_res.flags  = '{z: (w_sum[7:0] == 8'd0), n: 1'b0,
                                 h: w_sum_lo[4], c: w_sum[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                w_res.result = (i_op == OP_CP) ? i_acc : w_diff[7:0];
                w_res.flags  = '{z: (w_diff[7:0] == 8'd0), n: 1'b1,
                                 h: w_diff_lo[4], c: w_diff[8]};
                w_res.wb     = (i_op != OP_CP);
            end
            OP_AND: begin
                w_res.result = i_acc & i_operand;
                w_res.flags  = '{z: ((i_acc & i_operand) == 8'd0), n: 1'b0,
                                 h: 1'b1, c: 1'b0};
            end
            OP_XOR: begin
                w_res.result = i_acc ^ i_operand;
                w_res.flags  = '{z: ((i_acc ^ i_operand) == 8'd0), n: 1'b0,
                                 h: 1'b0, c: 1'b0};
            end
            OP_OR: begin
                w_res.result = i_acc | i_operand;
                w_res.flags  = '{z: ((i_acc | i_operand) == 8'd0), n: 1'b0,
                                 h: 1'b0, c: 1'b0};
            end
            OP_INC: begin
                w_res.result = w_inc;
                w_res.flags  = '{z: (w_inc == 8'd0), n: 1'b0,
                                 h: (i_operand[3:0] == 4'hF), c: i_flags.c};
            end
            OP_DEC: begin
                w_res.result = w_dec;
                w_res.flags  = '{z: (w_dec == 8'd0), n: 1'b1,
                                 h: (i_operand[3:0] == 4'h0), c: i_flags.c};
            end
            OP_DAA: begin
                w_res.result = w_daa;
                w_res.flags  = '{z: (w_daa == 8'd0), n: i_flags.n,
                                 h: 1'b0, c: w_daa_c};
            end
            OP_CPL: begin
                w_res.result = ~i_acc;
                w_res.flags  = '{z: i_flags.z, n: 1'b1, h: 1'b1, c: i_flags.c};
            end
            OP_CCF: begin
                w_res.flags = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: ~i_flags.c};
            end
            OP_SCF: begin
                w_res.flags = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            OP_RLCA: begin
                w_res.result = {i_acc[6:0], i_acc[7]};
                w_res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[7]};
            end
            OP_RLA: begin
                w_res.result = {i_acc[6:0], i_flags.c};
                w_res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[7]};
            end
            OP_RRCA: begin
                w_res.result = {i_acc[0], i_acc[7:1]};
                w_res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[0]};
            end
            OP_RRA: begin
                w_res.result = {i_flags.c, i_acc[7:1]};
                w_res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_acc[0]};
            end
            default: begin
                // unassigned codes: no operation, nothing written
                w_res.wb = 1'b0;
            end
        endcase
    end

    assign o_res = w_res;

endmodule

// ----- dv/cpu_8bit_alu_with_flags_unit_test.sv -----
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_unit_test
// Self-checking bench for the 8-bit ALU with Z N H C flags. A clocked driver
// feeds operation words from a queue, a built-in predictor computes each
// result, and a clocked monitor compares result, flags and write-back with
// the predictions in order. Both sides idle at random, the receiver holds
// off once for a long stretch, and the run ends with a quiet tail.
// ----------------------------------------------------------------------------
module cpu_8bit_alu_with_flags_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpualu_pkg::*;

    // One operation word as it crosses the request channel
    typedef struct packed {
        t_op    op;
        t_byte  acc;
        t_byte  operand;
        t_flags flags;
    } t_alu_word;

    localparam int unsigned RANDOM_WORDS = 1525;
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned QUIET_TAIL   = 120;
    localparam t_byte CORNER_BYTES [8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0,
                                           8'h99, 8'h9A, 8'h01, 8'h80};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cpualu_req_if alu_req ();
    cpualu_rsp_if alu_rsp ();

    cpu_8bit_alu_with_flags_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    t_alu_word   queued_words[$];
    t_alu_res    results_due[$];
    int unsigned words_queued   = 0;
    int unsigned words_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    logic [31:0] ops_hit        = '0;
    int unsigned send_gap       = 0;
    int unsigned recv_stall     = 0;
    logic        long_hold      = 1'b0;
    logic        quiet_tail     = 1'b0;

    always #5 i_clk = ~i_clk;

    // Expected ALU output for one word
    function automatic t_alu_res alu_outcome(t_alu_word w);
        t_alu_res   r;
        logic [8:0] wide;
        logic [4:0] nib;
        logic       cy;
        t_byte      adj;
        r.result = w.acc;
        r.flags  = w.flags;
        r.wb     = 1'b1;
        cy       = w.flags.c;
        case (w.op)
            OP_ADD, OP_ADC: begin
                if (w.op == OP_ADD) cy = 1'b0;
                wide = {1'b0, w.acc} + {1'b0, w.operand} + 9'(cy);
                nib  = {1'b0, w.acc[3:0]} + {1'b0, w.operand[3:0]} + 5'(cy);
                r.result = wide[7:0];
                r.flags  = '{z: wide[7:0] == 8'h00, n: 1'b0, h: nib[4], c: wide[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                if (w.op != OP_SBC) cy = 1'b0;
                // bit 8 / bit 4 of the widened difference is the borrow
                wide = {1'b0, w.acc} - {1'b0, w.operand} - 9'(cy);
                nib  = {1'b0, w.acc[3:0]} - {1'b0, w.operand[3:0]} - 5'(cy);
                r.flags  = '{z: wide[7:0] == 8'h00, n: 1'b1, h: nib[4], c: wide[8]};
                r.result = (w.op == OP_CP) ? w.acc : wide[7:0];
                r.wb     = (w.op != OP_CP);
            end
            OP_AND: begin
                r.result = w.acc & w.operand;
                r.flags  = '{z: r.result == 8'h00, n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_XOR: begin
                r.result = w.acc ^ w.operand;
                r.flags  = '{z: r.result == 8'h00, n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_OR: begin
                r.result = w.acc | w.operand;
                r.flags  = '{z: r.result == 8'h00, n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC: begin
                r.result = w.operand + 8'd1;
                r.flags  = '{z: r.result == 8'h00, n: 1'b0,
                             h: w.operand[3:0] == 4'hF, c: w.flags.c};
            end
            OP_DEC: begin
                r.result = w.operand - 8'd1;
                r.flags  = '{z: r.result == 8'h00, n: 1'b1,
                             h: w.operand[3:0] == 4'h0, c: w.flags.c};
            end
            OP_DAA: begin
                // N picks add or subtract mode; N carries over, C unless add mode sets it, H clears
                adj = w.acc;
                r.flags.h = 1'b0;
                if (w.flags.n) begin
                    if (w.flags.h) adj = adj - DAA_LO;
                    if (w.flags.c) adj = adj - DAA_HI;
                end else begin
                    if (w.flags.c || w.acc > DAA_HI_MAX) begin
                        adj = adj + DAA_HI;
                        r.flags.c = 1'b1;
                    end
                    if (w.flags.h || adj[3:0] > DAA_LO_MAX) adj = adj + DAA_LO;
                end
                r.result  = adj;
                r.flags.z = (adj == 8'h00);
            end
            OP_CPL: begin
                r.result  = ~w.acc;
                r.flags.n = 1'b1;
                r.flags.h = 1'b1;
            end
            OP_CCF: r.flags = '{z: w.flags.z, n: 1'b0, h: 1'b0, c: ~w.flags.c};
            OP_SCF: r.flags = '{z: w.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            OP_RLCA: begin
                r.result = {w.acc[6:0], w.acc[7]};
                r.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: w.acc[7]};
            end
            OP_RLA: begin
                r.result = {w.acc[6:0], w.flags.c};
                r.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: w.acc[7]};
            end
            OP_RRCA: begin
                r.result = {w.acc[0], w.acc[7:1]};
                r.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: w.acc[0]};
            end
            OP_RRA: begin
                r.result = {w.flags.c, w.acc[7:1]};
                r.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: w.acc[0]};
            end
            // unassigned codes pass through, nothing written
            default: r.wb = 1'b0;
        endcase
        return r;
    endfunction

    task automatic queue_word(t_op op, t_byte acc, t_byte operand, logic [3:0] flags);
        queued_words.push_back('{op: op, acc: acc, operand: operand, flags: t_flags'(flags)});
        words_queued++;
    endtask

    // Mostly full-range bytes, with a share of corner values
    function automatic t_byte pick_byte();
        if ($urandom_range(0, 3) == 0) return CORNER_BYTES[$urandom_range(0, 7)];
        return t_byte'($urandom_range(0, 255));
    endfunction

    task automatic wait_drained();
        while (words_accepted != words_queued || results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver: offers queued words, holds each until taken
    always @(posedge i_clk) begin : drive_words
        t_alu_word w;
        if (!i_rst_n) begin
            alu_req.valid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (alu_req.valid && alu_req.ready) begin
                w = '{op: alu_req.op, acc: alu_req.acc, operand: alu_req.operand,
                      flags: t_flags'(alu_req.flags_in)};
                results_due.push_back(alu_outcome(w));
                ops_hit[w.op] = 1'b1;
                words_accepted++;
            end
            if (!alu_req.valid || alu_req.ready) begin
                if (send_gap != 0) begin
                    send_gap      <= send_gap - 1;
                    alu_req.valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    // start an idle burst
                    send_gap      <= $urandom_range(0, 15);
                    alu_req.valid <= 1'b0;
                end else if (queued_words.size() != 0) begin
                    w = queued_words.pop_front();
                    alu_req.valid    <= 1'b1;
                    alu_req.op       <= w.op;
                    alu_req.acc      <= w.acc;
                    alu_req.operand  <= w.operand;
                    alu_req.flags_in <= w.flags;
                end else begin
                    alu_req.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_alu_res want;
        if (!i_rst_n) begin
            alu_rsp.ready <= 1'b0;
            recv_stall    <= 0;
        end else begin
            if (alu_rsp.valid && alu_rsp.ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result word: result %02h flags_out %01h write_back %0b",
                           alu_rsp.result, alu_rsp.flags_out, alu_rsp.write_back);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    results_seen++;
                    if (alu_rsp.result !== want.result) begin
                        $error("result: expected %02h, got %02h", want.result, alu_rsp.result);
                        mismatches++;
                    end
                    if (alu_rsp.flags_out !== want.flags) begin
                        $error("flags_out: expected %04b, got %04b",
                               want.flags, alu_rsp.flags_out);
                        mismatches++;
                    end
                    if (alu_rsp.write_back !== want.wb) begin
                        $error("write_back: expected %0b, got %0b",
                               want.wb, alu_rsp.write_back);
                        mismatches++;
                    end
                end
            end
            if (long_hold) begin
                alu_rsp.ready <= 1'b0;
            end else if (recv_stall != 0) begin
                recv_stall    <= recv_stall - 1;
                alu_rsp.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                recv_stall    <= $urandom_range(0, 15);
                alu_rsp.ready <= 1'b0;
            end else begin
                alu_rsp.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_op op;
        alu_req.valid    = 1'b0;
        alu_req.op       = OP_ADD;
        alu_req.acc      = '0;
        alu_req.operand  = '0;
        alu_req.flags_in = '0;
        alu_rsp.ready    = 1'b0;

        // Directed: field extremes, every operation, carry/borrow corners
        queue_word(OP_ADD,  8'h00, 8'h00, 4'b0000);
        queue_word(OP_ADD,  8'hFF, 8'hFF, 4'b1111);
        queue_word(OP_ADC,  8'hFF, 8'h00, 4'b0001);
        queue_word(OP_SUB,  8'h00, 8'h01, 4'b0000);
        queue_word(OP_SBC,  8'h10, 8'h0F, 4'b0001);
        queue_word(OP_SBC,  8'h00, 8'hFF, 4'b0001);
        queue_word(OP_CP,   8'h42, 8'h42, 4'b0000);
        queue_word(OP_AND,  8'hFF, 8'h00, 4'b0000);
        queue_word(OP_XOR,  8'hAA, 8'hAA, 4'b0000);
        queue_word(OP_OR,   8'hF0, 8'h0F, 4'b1111);
        queue_word(OP_INC,  8'h00, 8'hFF, 4'b0001);
        queue_word(OP_INC,  8'h00, 8'h0F, 4'b0000);
        queue_word(OP_DEC,  8'h00, 8'h01, 4'b0000);
        queue_word(OP_DEC,  8'hFF, 8'h00, 4'b0001);
        queue_word(OP_DAA,  8'h9A, 8'h00, 4'b0000);
        queue_word(OP_DAA,  8'h00, 8'h00, 4'b0111);
        queue_word(OP_CPL,  8'h5A, 8'h00, 4'b0000);
        queue_word(OP_CCF,  8'h33, 8'h00, 4'b1001);
        queue_word(OP_SCF,  8'hCC, 8'h00, 4'b0110);
        queue_word(OP_RLCA, 8'h80, 8'h00, 4'b0000);
        queue_word(OP_RLA,  8'h80, 8'h00, 4'b0000);
        queue_word(OP_RRCA, 8'h01, 8'h00, 4'b1110);
        queue_word(OP_RRA,  8'h01, 8'h00, 4'b0001);
        queue_word(t_op'(18), 8'h77, 8'h55, 4'b1010);
        queue_word(t_op'(31), 8'hFF, 8'hFF, 4'b1111);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender pauses here until the directed words are all back
        wait_drained();

        // Random: mostly defined operations, some unassigned codes
        repeat (RANDOM_WORDS) begin
            if ($urandom_range(0, 19) < 17) op = t_op'($urandom_range(0, 17));
            else                            op = t_op'($urandom_range(18, 31));
            queue_word(op, pick_byte(), pick_byte(), 4'($urandom_range(0, 15)));
        end

        // Long receiver hold-off while the driver keeps offering
        while (words_accepted < words_queued - RANDOM_WORDS + 300) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        long_hold <= 1'b0;

        // No idling on either side for the last words
        while (queued_words.size() > QUIET_TAIL) @(posedge i_clk);
        quiet_tail <= 1'b1;

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results from %0d operation words; %0d of 32 op codes seen.",
                 results_seen, words_accepted, $countones(ops_hit));
        $display("Random idling both sides, one %0d-cycle receiver hold, %0d mismatches.",
                 LONG_HOLD, mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
